>>> rtl/em2fat_pkg.sv
package em2fat_pkg;

    // Field widths
    localparam int TMS_W         = 48;   // width of the millisecond input
    localparam int TIME_BITS_DEF = 48;   // default count of used input bits
    localparam int YEAR_W        = 16;   // holds any year reachable from 48 bits
    localparam int FAT_W         = 32;
    localparam int STEP_W        = 4;

    // Span lengths in milliseconds
    localparam logic [TMS_W-1:0] MS_1970_TO_2000  = 48'd946684800000;
    localparam logic [TMS_W-1:0] MS_400_YEARS     = 48'd12622780800000;
    localparam logic [TMS_W-1:0] MS_FIRST_CENTURY = 48'd3155760000000;
    localparam logic [TMS_W-1:0] MS_CENTURY       = 48'd3155673600000;
    localparam logic [TMS_W-1:0] MS_YEAR          = 48'd31536000000;
    localparam logic [TMS_W-1:0] MS_LEAP_YEAR     = 48'd31622400000;
    localparam logic [TMS_W-1:0] MS_DAY           = 48'd86400000;
    localparam logic [TMS_W-1:0] MS_HOUR          = 48'd3600000;
    localparam logic [TMS_W-1:0] MS_MINUTE        = 48'd60000;
    localparam logic [TMS_W-1:0] MS_TWO_SEC       = 48'd2000;

    // Month lengths, two bits per month starting with January
    localparam logic [23:0] MONTHS_PLAIN = 24'hEEFBB3;
    localparam logic [23:0] MONTHS_LEAP  = 24'hEEFBB7;

    // Calendar anchors
    localparam logic [YEAR_W-1:0] YEAR_1970 = 16'd1970;
    localparam logic [YEAR_W-1:0] YEAR_2000 = 16'd2000;
    localparam logic [YEAR_W-1:0] YEAR_1980 = 16'd1980;
    localparam logic [YEAR_W-1:0] YEAR_2107 = 16'd2107;
    localparam logic [3:0]        MONTH_DEC = 4'd12;

    // Program step addresses
    localparam logic [STEP_W-1:0] STEP_EPOCH = 4'd0;
    localparam logic [STEP_W-1:0] STEP_Q400  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_C1    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_CENT  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_YEAR  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_MONTH = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DAY   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_HOUR  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_MIN   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SEC   = 4'd9;

    // Which span the step compares against
    typedef enum logic [3:0] {
        K_EPOCH,
        K_Q400,
        K_C1,
        K_CENT,
        K_YEAR,
        K_MONTH,
        K_DAY,
        K_HOUR,
        K_MIN,
        K_TWO_SEC
    } ksel_t;

    // Counter bumped when the span fits
    typedef enum logic [3:0] {
        INC_NONE,
        INC_Y400,
        INC_Y100,
        INC_Y1,
        INC_MONTH,
        INC_DAY,
        INC_HOUR,
        INC_MIN,
        INC_SEC
    } inc_t;

    // Side effect when the span does not fit
    typedef enum logic [1:0] {
        FA_NONE,
        FA_Y1970,
        FA_MONTHS,
        FA_DONE
    } fail_t;

    typedef struct packed {
        ksel_t             ksel;
        inc_t              inc;
        logic [STEP_W-1:0] pass_step;
        fail_t             fail_act;
        logic [STEP_W-1:0] fail_step;
    } ctrl_t;

    // Month length in ms from its two-bit code
    function automatic logic [TMS_W-1:0] month_ms(input logic [1:0] code);
        logic [TMS_W-1:0] len;
        unique case (code)
            2'd0: len = 48'd2419200000;
            2'd1: len = 48'd2505600000;
            2'd2: len = 48'd2592000000;
            2'd3: len = 48'd2678400000;
        endcase
        return len;
    endfunction

    // Control store: each step tests one span and loops or moves on
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        unique case (step)
            STEP_EPOCH: cw = '{K_EPOCH,   INC_NONE,  STEP_Q400,  FA_Y1970,  STEP_YEAR};
            STEP_Q400:  cw = '{K_Q400,    INC_Y400,  STEP_Q400,  FA_NONE,   STEP_C1};
            STEP_C1:    cw = '{K_C1,      INC_Y100,  STEP_CENT,  FA_NONE,   STEP_YEAR};
            STEP_CENT:  cw = '{K_CENT,    INC_Y100,  STEP_CENT,  FA_NONE,   STEP_YEAR};
            STEP_YEAR:  cw = '{K_YEAR,    INC_Y1,    STEP_YEAR,  FA_MONTHS, STEP_MONTH};
            STEP_MONTH: cw = '{K_MONTH,   INC_MONTH, STEP_MONTH, FA_NONE,   STEP_DAY};
            STEP_DAY:   cw = '{K_DAY,     INC_DAY,   STEP_DAY,   FA_NONE,   STEP_HOUR};
            STEP_HOUR:  cw = '{K_HOUR,    INC_HOUR,  STEP_HOUR,  FA_NONE,   STEP_MIN};
            STEP_MIN:   cw = '{K_MIN,     INC_MIN,   STEP_MIN,   FA_NONE,   STEP_SEC};
            STEP_SEC:   cw = '{K_TWO_SEC, INC_SEC,   STEP_SEC,   FA_DONE,   STEP_SEC};
            default:    cw = '{K_TWO_SEC, INC_NONE,  STEP_SEC,   FA_DONE,   STEP_SEC};
        endcase
        return cw;
    endfunction

endpackage

>>> rtl/epoch_ms_to_fat_timestamp.sv
// Channel  | Signals                      | Payload
// ---------+------------------------------+-------------------------------------
// input    | s_tvalid s_tready s_tdata    | utc_ms [47:0]
// output   | m_tvalid m_tready m_tdata    | fat_timestamp [31:0]
//          | m_tuser                      | year_out_of_range [0]
//
// One transaction at a time runs through a ten-step control store that
// tests one span per cycle while running (the last step stalls while the
// output register is full): the epoch span, the 400-year loop, the first
// century and century loop, the year loop and the month/day/hour/minute/second
// loops. A new input is not taken until the current conversion finishes.
// Reset clears the sequencer and the output valid; other registers are not reset.
// A finished result waits in the output register; the next input is taken
// while it waits, and the last step holds if the register is still full.
module epoch_ms_to_fat_timestamp
    import em2fat_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TMS_W-1:0]  s_tdata,   // [47:0] utc_ms
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [FAT_W-1:0]  m_tdata,   // [31:0] fat_timestamp
    output logic              m_tuser    // [0] year_out_of_range
);

    localparam int W = (TIME_BITS < TMS_W) ? TIME_BITS : TMS_W;

    // Control state
    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   pc_reg, pc_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Datapath registers
    logic [W-1:0]        t_reg, t_next;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [6:0]          y100_reg, y100_next;   // year mod 100
    logic [8:0]          y400_reg, y400_next;   // year mod 400
    logic [23:0]         months_reg, months_next;
    logic [3:0]          m_reg, m_next;
    logic [4:0]          d_reg, d_next;
    logic [4:0]          h_reg, h_next;
    logic [5:0]          n_reg, n_next;
    logic [4:0]          s2_reg, s2_next;
    logic [FAT_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    ctrl_t               cw;
    logic                leap;
    logic [TMS_W-1:0]    t_wide;
    logic [TMS_W-1:0]    k;
    logic [TMS_W-1:0]    diff;
    logic                pass;
    logic                out_free;
    logic [YEAR_W-1:0]   year_rel;

    assign s_tready = !busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Leap test from the running residues
    assign leap = (year_reg[1:0] == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));

    // Current control word and the span it selects
    assign cw     = ucode(pc_reg);
    assign t_wide = TMS_W'(t_reg);

    always_comb
    begin
        unique case (cw.ksel)
            K_EPOCH:   k = MS_1970_TO_2000;
            K_Q400:    k = MS_400_YEARS;
            K_C1:      k = MS_FIRST_CENTURY;
            K_CENT:    k = MS_CENTURY;
            K_YEAR:    k = leap ? MS_LEAP_YEAR : MS_YEAR;
            K_MONTH:   k = month_ms(months_reg[1:0]);
            K_DAY:     k = MS_DAY;
            K_HOUR:    k = MS_HOUR;
            K_MIN:     k = MS_MINUTE;
            K_TWO_SEC: k = MS_TWO_SEC;
            default:   k = MS_TWO_SEC;
        endcase
    end

    // Span fits; December takes the remainder without a test
    assign diff     = t_wide - k;
    assign pass     = (t_wide >= k) && !((cw.ksel == K_MONTH) && (m_reg == MONTH_DEC));
    assign out_free = !m_tvalid_reg || m_tready;
    assign year_rel = year_reg - YEAR_1980;

    // Sequencer and datapath next state
    always_comb
    begin
        busy_next     = busy_reg;
        pc_next       = pc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        t_next        = t_reg;
        year_next     = year_reg;
        y100_next     = y100_reg;
        y400_next     = y400_reg;
        months_next   = months_reg;
        m_next        = m_reg;
        d_next        = d_reg;
        h_next        = h_reg;
        n_next        = n_reg;
        s2_next       = s2_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (!busy_reg)
        begin
            if (s_tvalid)
            begin
                busy_next = 1'b1;
                pc_next   = STEP_EPOCH;
                t_next    = s_tdata[W-1:0];
                year_next = YEAR_2000;
                y100_next = 7'd0;
                y400_next = 9'd0;
                m_next    = 4'd1;
                d_next    = 5'd1;
                h_next    = 5'd0;
                n_next    = 6'd0;
                s2_next   = 5'd0;
            end
        end
        else if (pass)
        begin
            t_next  = diff[W-1:0];
            pc_next = cw.pass_step;
            unique case (cw.inc)
                INC_NONE:  ;
                INC_Y400:  year_next = year_reg + 16'd400;
                INC_Y100:
                begin
                    year_next = year_reg + 16'd100;
                    y400_next = (y400_reg >= 9'd300) ? y400_reg - 9'd300 : y400_reg + 9'd100;
                end
                INC_Y1:
                begin
                    year_next = year_reg + 16'd1;
                    y100_next = (y100_reg == 7'd99) ? 7'd0 : y100_reg + 7'd1;
                    y400_next = (y400_reg == 9'd399) ? 9'd0 : y400_reg + 9'd1;
                end
                INC_MONTH:
                begin
                    m_next      = m_reg + 4'd1;
                    months_next = months_reg >> 2;
                end
                INC_DAY:   d_next  = d_reg + 5'd1;
                INC_HOUR:  h_next  = h_reg + 5'd1;
                INC_MIN:   n_next  = n_reg + 6'd1;
                INC_SEC:   s2_next = s2_reg + 5'd1;
                default:   ;
            endcase
        end
        else
        begin
            pc_next = cw.fail_step;
            unique case (cw.fail_act)
                FA_NONE:   ;
                FA_Y1970:
                begin
                    year_next = YEAR_1970;
                    y100_next = 7'd70;
                    y400_next = 9'd370;
                end
                FA_MONTHS: months_next = leap ? MONTHS_LEAP : MONTHS_PLAIN;
                FA_DONE:
                begin
                    // Hand over only when the output register is free
                    if (out_free)
                    begin
                        busy_next     = 1'b0;
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = {year_rel[6:0], m_reg, d_reg, h_reg, n_reg, s2_reg};
                        m_tuser_next  = (year_reg < YEAR_1980) || (year_reg > YEAR_2107);
                    end
                    else
                    begin
                        pc_next = pc_reg;
                    end
                end
                default:   ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pc_reg       <= STEP_EPOCH;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        year_reg    <= year_next;
        y100_reg    <= y100_next;
        y400_reg    <= y400_next;
        months_reg  <= months_next;
        m_reg       <= m_next;
        d_reg       <= d_next;
        h_reg       <= h_next;
        n_reg       <= n_next;
        s2_reg      <= s2_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef SYNTH
    // Program counter stays inside the control store
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= STEP_SEC))
        else $error("step counter outside program");

    // A new transaction starts the program at its first step
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (busy_reg && (pc_reg == STEP_EPOCH)))
        else $error("conversion did not start");

    // Month counter stays 1..12 while stepping
    a_month: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (pc_reg >= STEP_MONTH)) |-> ((m_reg >= 4'd1) && (m_reg <= MONTH_DEC)))
        else $error("month counter out of range");

    // Year residues stay in their moduli
    a_resid: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((y100_reg < 7'd100) && (y400_reg < 9'd400)))
        else $error("year residue out of range");

    // A result appears only as the conversion finishes
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(busy_reg) && !busy_reg))
        else $error("result without finished conversion");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int TMS_W = em2fat_pkg::TMS_W;
    localparam int FAT_W = em2fat_pkg::FAT_W;

    // Span lengths in ms
    localparam longint unsigned SPAN_TO_2000  = 64'd946684800000;
    localparam longint unsigned SPAN_400Y     = 64'd12622780800000;
    localparam longint unsigned SPAN_CENT1    = 64'd3155760000000;
    localparam longint unsigned SPAN_CENT     = 64'd3155673600000;
    localparam longint unsigned SPAN_YEAR     = 64'd31536000000;
    localparam longint unsigned SPAN_LEAP     = 64'd31622400000;
    localparam longint unsigned SPAN_DAY      = 64'd86400000;
    localparam int unsigned     SPAN_DAY32    = 32'd86400000;
    localparam int unsigned     SPAN_HOUR     = 32'd3600000;
    localparam int unsigned     SPAN_MINUTE   = 32'd60000;
    localparam int unsigned     SPAN_SECOND   = 32'd1000;

    // Month-length codes, two bits per month from January
    localparam logic [23:0] MONTH_CODES_PLAIN = 24'hEEFBB3;
    localparam logic [23:0] MONTH_CODES_LEAP  = 24'hEEFBB7;

    localparam int RANDOM_ITEMS = 1328;
    localparam int DRAIN_AT     = 640;
    localparam int QUIET_TAIL   = 150;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        logic [FAT_W-1:0] fat;
        logic             out_of_range;
    } fat_result_t;

    typedef struct packed {
        logic [TMS_W-1:0] ms;
        logic             drain_first;
    } utc_item_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [TMS_W-1:0] s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [FAT_W-1:0] m_tdata;   // [31:0] fat_timestamp
    logic             m_tuser;   // [0] year_out_of_range

    utc_item_t   pending_q[$];
    fat_result_t expected_q[$];
    utc_item_t   next_item;
    fat_result_t want;
    int          src_gap    = 0;
    int          snk_gap    = 0;
    int          mismatches = 0;

    int unsigned hot_years [0:14] = '{1979, 1980, 1999, 2000, 2099, 2100, 2101, 2107,
                                      2108, 2199, 2200, 2300, 2399, 2400, 2401};
    int unsigned day_marks [0:5]  = '{0, 58, 59, 60, 364, 365};

    epoch_ms_to_fat_timestamp u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic bit leap_year(input longint unsigned yr);
        if (yr % 4 != 0)
            return 1'b0;
        if (yr % 100 != 0)
            return 1'b1;
        return (yr % 400) == 0;
    endfunction

    // ms from the epoch to Jan 1 of the given year
    function automatic longint unsigned year_start_ms(input int unsigned yr);
        longint unsigned acc;
        acc = 0;
        for (int unsigned yy = 1970; yy < yr; yy++)
            acc += leap_year(yy) ? SPAN_LEAP : SPAN_YEAR;
        return acc;
    endfunction

    // Calendar breakdown of one ms count into the FAT date-time word
    function automatic fat_result_t predict_fat(input logic [TMS_W-1:0] utc);
        longint unsigned t;
        longint unsigned yr;
        longint unsigned span;
        logic [23:0]     mcodes;
        int unsigned     mon;
        int unsigned     rem;
        int unsigned     day;
        int unsigned     hr;
        int unsigned     mn;
        int unsigned     sec;
        fat_result_t     res;
        t = utc;
        mcodes = MONTH_CODES_PLAIN;
        // Before 2000 years are stepped one at a time from 1970
        if (t < SPAN_TO_2000)
        begin
            yr = 1970;
        end
        else
        begin
            t -= SPAN_TO_2000;
            yr = 2000 + 400 * (t / SPAN_400Y);
            t = t % SPAN_400Y;
            // First century of a 400-year span carries the extra leap day
            if (t >= SPAN_CENT1)
            begin
                t -= SPAN_CENT1;
                yr += 100 + 100 * (t / SPAN_CENT);
                t = t % SPAN_CENT;
            end
        end
        for (int i = 0; i < 128; i++)
        begin
            span = leap_year(yr) ? SPAN_LEAP : SPAN_YEAR;
            mcodes = leap_year(yr) ? MONTH_CODES_LEAP : MONTH_CODES_PLAIN;
            if (t < span)
                break;
            t -= span;
            yr++;
        end
        mon = 1;
        while (mon < 12)
        begin
            span = (64'd28 + mcodes[1:0]) * SPAN_DAY;
            if (t < span)
                break;
            t -= span;
            mcodes = mcodes >> 2;
            mon++;
        end
        rem = 32'(t);
        day = rem / SPAN_DAY32 + 1;
        rem = rem % SPAN_DAY32;
        hr = rem / SPAN_HOUR;
        rem = rem % SPAN_HOUR;
        mn = rem / SPAN_MINUTE;
        rem = rem % SPAN_MINUTE;
        sec = rem / SPAN_SECOND;
        res.fat = {7'(yr - 1980), 4'(mon), 5'(day), 5'(hr), 6'(mn), 5'(sec / 2)};
        res.out_of_range = (yr < 1980) || (yr > 2107);
        return res;
    endfunction

    // Idling only outside the quiet tail, and in two of every three stretches of 100 items
    function automatic bit idling_allowed();
        return pending_q.size() > QUIET_TAIL && (pending_q.size() / 100) % 3 != 0;
    endfunction

    task automatic note_mismatch(input string what, input longint unsigned exp_v,
                                 input longint unsigned act_v);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch %0s: expected 0x%0h, got 0x%0h at %0t",
                     what, exp_v, act_v, $realtime);
    endtask

    // Input driver: records the expectation for every accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_q.push_back(predict_fat(s_tdata));
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_q.size() == 0 ||
                     (pending_q[0].drain_first && expected_q.size() != 0))
            begin
                s_tvalid <= 1'b0;
            end
            else
            begin
                next_item = pending_q.pop_front();
                s_tdata  <= next_item.ms;
                s_tvalid <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 19);
            end
        end
    end

    // Output back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idling_allowed() && $urandom_range(0, 7) == 0)
                snk_gap = $urandom_range(1, 19);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                note_mismatch("unexpected transaction", 0, m_tdata);
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata !== want.fat)
                    note_mismatch("fat_timestamp", want.fat, m_tdata);
                if (m_tuser !== want.out_of_range)
                    note_mismatch("year_out_of_range", want.out_of_range, m_tuser);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [TMS_W-1:0] ms;
        int               pick;
        int unsigned      yr;
        int unsigned      dd;

        // Directed: field extremes, epoch and century edges, leap days, FAT range edges
        pending_q.push_back('{48'd0, 1'b0});
        pending_q.push_back('{48'd1999, 1'b0});
        pending_q.push_back('{48'd2000, 1'b0});
        pending_q.push_back('{48'd59999, 1'b0});
        pending_q.push_back('{48'(year_start_ms(1980) - 1), 1'b0});
        pending_q.push_back('{48'(year_start_ms(1980)), 1'b0});
        pending_q.push_back('{48'(SPAN_TO_2000 - 1), 1'b0});
        pending_q.push_back('{48'(SPAN_TO_2000), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2000) + 59 * SPAN_DAY), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2000) + 60 * SPAN_DAY - 1), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2100) - 1), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2100) + 59 * SPAN_DAY - 1), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2100) + 59 * SPAN_DAY), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2101)), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2108) - 1), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2108)), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2200) - 1), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2400)), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2400) + 59 * SPAN_DAY), 1'b0});
        pending_q.push_back('{48'(year_start_ms(2024) + 100 * SPAN_DAY + 45297500), 1'b0});
        pending_q.push_back('{48'h5555_5555_5555, 1'b0});
        pending_q.push_back('{48'hAAAA_AAAA_AAAA, 1'b0});
        pending_q.push_back('{48'hFFFF_FFFF_FFFF, 1'b0});

        // Random: full-range counts, whole years near the FAT range, and day edges
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                ms = 48'({$urandom, $urandom});
            end
            else if (pick < 60)
            begin
                yr = $urandom_range(1970, 2110);
                ms = 48'(year_start_ms(yr) + ({$urandom, $urandom} % SPAN_LEAP));
            end
            else
            begin
                if ($urandom_range(0, 1) != 0)
                    yr = $urandom_range(1970, 2120);
                else
                    yr = hot_years[$urandom_range(0, 14)];
                dd = day_marks[$urandom_range(0, 5)];
                if ($urandom_range(0, 1) != 0)
                    ms = 48'(year_start_ms(yr) + dd * SPAN_DAY + $urandom_range(0, 2999));
                else
                    ms = 48'(year_start_ms(yr) + (dd + 1) * SPAN_DAY - 1
                             - $urandom_range(0, 2999));
            end
            pending_q.push_back('{ms, (n == 0 || n == DRAIN_AT)});
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
